### hw/rtl/afclrc_pkg.sv
// Shared types, constants and character helpers for the ASCII frame checker.
// Used by afclrc_frame and ascii_frame_checker_lrc_core; no dependencies.
package afclrc_pkg;

  // Frame capacity in characters, start character included
  localparam int MAX_CHARS = 512;
  localparam int COUNT_W   = $clog2(MAX_CHARS + 2);
  localparam int PAIR_W    = $clog2(MAX_CHARS);

  localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_W'(MAX_CHARS + 1);
  localparam logic [COUNT_W-1:0] COUNT_CAP  = COUNT_W'(MAX_CHARS);
  localparam logic [COUNT_W-1:0] COUNT_MIN  = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_SIZE = COUNT_W'(9);
  localparam logic [COUNT_W-1:0] COUNT_ADDR = COUNT_W'(2);
  localparam logic [PAIR_W-1:0]  PAIR_DATA  = PAIR_W'(4);

  localparam logic [7:0] BOARD_ADDRESS_RESET = 8'h01;

  // Verdict codes
  localparam logic [2:0] VERDICT_SILENT   = 3'd0;
  localparam logic [2:0] VERDICT_ACCEPTED = 3'd1;
  localparam logic [2:0] VERDICT_SIZE_ERR = 3'd2;
  localparam logic [2:0] VERDICT_HEX_ERR  = 3'd3;
  localparam logic [2:0] VERDICT_LRC_ERR  = 3'd4;

  // ASCII characters
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;
  // 'A' - 10, so that 'A' decodes to ten
  localparam logic [7:0] CHAR_A_BASE = 8'h37;

  typedef struct packed {
    logic [7:0] frame_char;
    logic       last_char;
  } afclrc_in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic        frame_done;
    logic [2:0]  verdict;
    logic [7:0]  frame_address;
    logic [15:0] function_code;
    logic [7:0]  data_length;
  } afclrc_out_t;

  // Result of one character: whether it yields a result item, and the item
  typedef struct packed {
    logic        present;
    afclrc_out_t item;
  } afclrc_res_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CHAR_0) && (c <= CHAR_9)) || ((c >= CHAR_A) && (c <= CHAR_F));
  endfunction

  // Non-hex characters still decode, modulo 16
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = (c <= CHAR_9) ? (c - CHAR_0) : (c - CHAR_A_BASE);
    return v[3:0];
  endfunction

endpackage

### hw/rtl/afclrc_frame.sv
// Per-frame decode state and verdict logic for the ASCII frame checker.
// Depends on afclrc_pkg; instantiated by ascii_frame_checker_lrc_core.
module afclrc_frame import afclrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  board_address,
  input  logic        in_fire,
  input  afclrc_in_t  in_item,
  output afclrc_res_t res
);

  logic [COUNT_W-1:0] char_count, char_count_next;
  logic [3:0]         high_nibble, high_nibble_next;
  logic [7:0]         held_byte, held_byte_next;
  logic [PAIR_W-1:0]  pair_count, pair_count_next;
  logic [7:0]         byte_sum, byte_sum_next;
  logic [7:0]         address_reg, address_reg_next;
  logic [15:0]        function_reg, function_reg_next;
  logic               hex_bad, hex_bad_next;
  logic               addr_bad, addr_bad_next;

  logic               active;
  logic [3:0]         nib;
  logic [7:0]         pair_byte;
  logic               emit;
  logic [PAIR_W-1:0]  data_pos;
  logic [PAIR_W-1:0]  data_len;
  logic [2:0]         verdict;

  // Decode one character against the current frame state
  always_comb begin
    char_count_next   = char_count;
    high_nibble_next  = high_nibble;
    held_byte_next    = held_byte;
    pair_count_next   = pair_count;
    byte_sum_next     = byte_sum;
    address_reg_next  = address_reg;
    function_reg_next = function_reg;
    hex_bad_next      = hex_bad;
    addr_bad_next     = addr_bad;
    emit              = 1'b0;

    active    = (char_count != '0) && (char_count < COUNT_CAP);
    nib       = nibble_of(in_item.frame_char);
    pair_byte = {high_nibble, nib};
    data_pos  = pair_count - PAIR_DATA;

    if (active) begin
      if (!is_hex(in_item.frame_char)) begin
        hex_bad_next = 1'b1;
        if (char_count <= COUNT_ADDR) begin
          addr_bad_next = 1'b1;
        end
      end
      if (char_count[0]) begin
        high_nibble_next = nib;
      end else begin
        // Data bytes go out one pair late, so the final pair stays as the LRC
        emit = (pair_count >= PAIR_DATA);
        if (pair_count == PAIR_W'(0)) begin
          address_reg_next = pair_byte;
        end else if (pair_count == PAIR_W'(1)) begin
          function_reg_next[15:8] = pair_byte;
        end else if (pair_count == PAIR_W'(2)) begin
          function_reg_next[7:0] = pair_byte;
        end else begin
          held_byte_next = pair_byte;
        end
        byte_sum_next   = byte_sum + pair_byte;
        pair_count_next = pair_count + PAIR_W'(1);
      end
    end

    if (char_count != COUNT_SAT) begin
      char_count_next = char_count + COUNT_W'(1);
    end

    // Verdict on the frame as it stands after this character
    data_len = pair_count_next - PAIR_DATA;
    if ((char_count_next < COUNT_MIN) || addr_bad_next ||
        (address_reg_next != board_address)) begin
      verdict = VERDICT_SILENT;
    end else if ((char_count_next < COUNT_SIZE) || !char_count_next[0] ||
                 (char_count_next > COUNT_CAP)) begin
      verdict = VERDICT_SIZE_ERR;
    end else if (hex_bad_next) begin
      verdict = VERDICT_HEX_ERR;
    end else if (byte_sum_next != 8'd0) begin
      verdict = VERDICT_LRC_ERR;
    end else begin
      verdict = VERDICT_ACCEPTED;
    end

    res.present                = emit || in_item.last_char;
    res.item.byte_valid        = emit;
    res.item.byte_value        = emit ? held_byte : 8'd0;
    res.item.byte_index        = emit ? 8'(data_pos) : 8'd0;
    res.item.frame_done        = in_item.last_char;
    res.item.verdict           = in_item.last_char ? verdict : VERDICT_SILENT;
    res.item.frame_address     = in_item.last_char ? address_reg_next : 8'd0;
    res.item.function_code     = in_item.last_char ? function_reg_next : 16'd0;
    res.item.data_length       = (in_item.last_char && (pair_count_next >= PAIR_DATA)) ?
                                 8'(data_len) : 8'd0;
  end

  // Advance the frame state on each request; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst || (in_fire && in_item.last_char)) begin
      char_count   <= '0;
      high_nibble  <= '0;
      held_byte    <= '0;
      pair_count   <= '0;
      byte_sum     <= '0;
      address_reg  <= '0;
      function_reg <= '0;
      hex_bad      <= 1'b0;
      addr_bad     <= 1'b0;
    end else if (in_fire) begin
      char_count   <= char_count_next;
      high_nibble  <= high_nibble_next;
      held_byte    <= held_byte_next;
      pair_count   <= pair_count_next;
      byte_sum     <= byte_sum_next;
      address_reg  <= address_reg_next;
      function_reg <= function_reg_next;
      hex_bad      <= hex_bad_next;
      addr_bad     <= addr_bad_next;
    end
  end

endmodule

### hw/rtl/ascii_frame_checker_lrc_core.sv
// Top level of the ASCII frame checker: configuration register, output register
// and skid stage. Depends on afclrc_pkg and afclrc_frame.

// The block takes one frame character per cycle and answers within the same
// cycle's logic: a data byte, a frame verdict or both are registered into the
// output register, or the skid stage if the output stalls, when the request is
// accepted. Sustained rate is one character per cycle, set by the combinational
// decode in afclrc_frame. A one-entry skid stage behind the output register
// lets one more request in while a result waits; in_ready drops only while the
// skid stage is full. board_address resets to 1 and is written through the cfg
// channel, which is always ready; write it only between frames.
module ascii_frame_checker_lrc_core import afclrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  afclrc_in_t  in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output afclrc_out_t out_item
);

  logic        [7:0] board_address;
  logic              skid_valid;
  afclrc_out_t       skid_item;
  afclrc_res_t       res;
  logic              in_fire;
  logic              res_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign res_fire  = in_fire && res.present;

  // Hold the station address
  always_ff @(posedge clk) begin
    if (rst) begin
      board_address <= BOARD_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      board_address <= cfg_data;
    end
  end

  afclrc_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .board_address (board_address),
    .in_fire       (in_fire),
    .in_item       (in_item),
    .res           (res)
  );

  // Output register with skid: park a new result while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (res_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (res_fire) begin
        skid_item <= res.item;
      end
    end else if (skid_valid) begin
      out_item <= skid_item;
    end else if (res_fire) begin
      out_item <= res.item;
    end
  end

  // The skid stage only fills behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result with the output register empty");

  // Every result delivered carries a data byte or a verdict
  a_result_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.byte_valid || out_item.frame_done))
    else $error("empty result item in output register");

  // A verdict other than silent only comes with the end of a frame
  a_verdict_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.verdict != VERDICT_SILENT)) |-> out_item.frame_done)
    else $error("verdict given without frame end");

  // A full skid stage drains before another request enters
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> !skid_valid)
    else $error("skid stage failed to drain");

endmodule
